/* src/time_constant_nonlinearity_assert.svh */
// assertion macros for the time constant nonlinearity block
// expects a clock named aclk and an active-low reset named aresetn in scope
`ifndef TIME_CONSTANT_NONLINEARITY_ASSERT_SVH
`define TIME_CONSTANT_NONLINEARITY_ASSERT_SVH

// condition and consequence in the same cycle
`define TCN_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (cons)) else $error("tcn check failed");

// condition, then consequence in the cycle after
`define TCN_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (cons)) else $error("tcn check failed");

`endif

/* src/tcn_pkg.sv */
// constants, types and helper functions for the time constant nonlinearity
// no dependencies
`default_nettype none

package tcn_pkg;

    // input sample width, Q4.20 at the default
    localparam int SAMPLE_WIDTH = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAU_MIN     = 2'd0,
        CFG_TAU_MAX     = 2'd1,
        CFG_FLOOR_RATIO = 2'd2,
        CFG_DECAY_RATE  = 2'd3
    } cfg_reg_t;

    localparam logic [31:0] TAU_MIN_RESET     = 32'd0;
    localparam logic [31:0] TAU_MAX_RESET     = 32'hFFFF_FFFF;
    localparam logic [15:0] FLOOR_RATIO_RESET = 16'd3277;
    localparam logic [23:0] DECAY_RATE_RESET  = 24'd65536;

    // which bound was applied
    typedef enum logic [1:0] {
        BOUND_NONE = 2'd0,
        BOUND_MIN  = 2'd1,
        BOUND_MAX  = 2'd2
    } bound_t;

    // how the exponential of an item is settled
    typedef enum logic [1:0] {
        EXP_CALC = 2'd0,
        EXP_ONE  = 2'd1,
        EXP_TWO  = 2'd2,
        EXP_ZERO = 2'd3
    } exp_kind_t;

    // fixed point constants
    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [33:0] TWO_Q32   = 34'h2_0000_0000;
    localparam int          Y_FRAC_LIMIT_BITS = 29;  // exp argument saturates at 32.0 in Q.24
    localparam logic [5:0]  MAX_SHIFT = 6'd32;
    localparam logic [16:0] ONE_Q16   = 17'h1_0000;

    // scaled argument product width, never narrower than the saturation test needs
    localparam int T_W = ((SAMPLE_WIDTH + 24) > 42) ? (SAMPLE_WIDTH + 24) : 42;
    localparam int Y_W = T_W - 12;

    // polynomial degree and pipeline stage map
    localparam int HORNER_DEG = 7;
    localparam int ST_ABS     = 0;
    localparam int ST_SCALE   = 1;
    localparam int ST_LOG2    = 2;
    localparam int ST_FRAC    = 3;
    localparam int ST_HORNER  = 4;
    localparam int ST_EXP     = ST_HORNER + 2 * HORNER_DEG;
    localparam int ST_MIX     = ST_EXP + 1;
    localparam int ST_MUL     = ST_MIX + 1;
    localparam int ST_OUT     = ST_MUL + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    // reciprocals for floor division of a 32 bit value by a small constant
    localparam logic [32:0] RECIP_3 = 33'h0_AAAA_AAAB;  // shift 33
    localparam logic [32:0] RECIP_5 = 33'h0_CCCC_CCCD;  // shift 34
    localparam logic [32:0] RECIP_6 = 33'h0_AAAA_AAAB;  // shift 34
    localparam logic [32:0] RECIP_7 = 33'h1_2492_4925;  // shift 35

    // floor(x / k) for k from 1 to 7, k a constant at every call
    function automatic logic [31:0] div_small(input logic [31:0] x, input int unsigned k);
        logic [64:0] prod;
        logic [31:0] q;
        prod = '0;
        q    = x;
        case (k)
            1: q = x;
            2: q = {1'b0, x[31:1]};
            3: begin
                prod = 65'(x) * 65'(RECIP_3);
                q    = prod[64:33];
            end
            4: q = {2'b00, x[31:2]};
            5: begin
                prod = 65'(x) * 65'(RECIP_5);
                q    = 32'(prod[64:34]);
            end
            6: begin
                prod = 65'(x) * 65'(RECIP_6);
                q    = 32'(prod[64:34]);
            end
            7: begin
                prod = 65'(x) * 65'(RECIP_7);
                q    = 32'(prod[64:35]);
            end
            default: q = x;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

/* src/time_constant_nonlinearity.sv */
// time constant nonlinearity: pipelined exp-shaped time constant with bounds
// depends on tcn_pkg and time_constant_nonlinearity_assert.svh
`default_nettype none

// One sample in, one time constant out: tau_max scaled by floor + (1 - floor)
// * exp(-|sample| * decay_rate) for decay_rate >= 0, held between tau_min and
// tau_max, with bound_hit telling which bound applied. A new sample can be
// taken every cycle unless stalled; the result passes through 22 register
// stages, most of them in the exponential: range reduction to a power of two,
// then seven Horner steps of two stages each (multiply, then divide by the
// step constant and subtract). Each stage moves independently, so empty
// stages fill while the output waits. Configuration is written through a plain
// write port, by the user only while the block is empty; nothing enforces it.
`include "time_constant_nonlinearity_assert.svh"

module time_constant_nonlinearity (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration writes
    input  wire logic                                 cfg_wen,
    input  wire logic [tcn_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  wire logic [tcn_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sample channel
    input  wire logic                                 s_valid,
    output      logic                                 s_ready,
    input  wire logic signed [tcn_pkg::SAMPLE_WIDTH-1:0] s_sample,
    // result channel
    output      logic                                 m_valid,
    input  wire logic                                 m_ready,
    output      logic [31:0]                          m_tau_out,
    output      logic [1:0]                           m_bound_hit
);

    localparam int W    = tcn_pkg::SAMPLE_WIDTH;
    localparam int NS   = tcn_pkg::NUM_STAGES;
    localparam int HST  = tcn_pkg::ST_HORNER;
    localparam int HDEG = tcn_pkg::HORNER_DEG;
    localparam int EST  = tcn_pkg::ST_EXP;

    // configuration registers
    logic [31:0] tau_min_reg;
    logic [31:0] tau_max_reg;
    logic [15:0] floor_ratio_reg;
    logic [23:0] decay_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_min_reg     <= tcn_pkg::TAU_MIN_RESET;
            tau_max_reg     <= tcn_pkg::TAU_MAX_RESET;
            floor_ratio_reg <= tcn_pkg::FLOOR_RATIO_RESET;
            decay_rate_reg  <= tcn_pkg::DECAY_RATE_RESET;
        end else if (cfg_wen) begin
            case (tcn_pkg::cfg_reg_t'(cfg_idx))
                tcn_pkg::CFG_TAU_MIN:     tau_min_reg     <= cfg_wdata[31:0];
                tcn_pkg::CFG_TAU_MAX:     tau_max_reg     <= cfg_wdata[31:0];
                tcn_pkg::CFG_FLOOR_RATIO: floor_ratio_reg <= cfg_wdata[15:0];
                tcn_pkg::CFG_DECAY_RATE:  decay_rate_reg  <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // magnitude and sign of the decay rate
    logic        grow;
    logic [23:0] rate_abs;
    assign grow     = decay_rate_reg[23];
    assign rate_abs = grow ? (24'd0 - decay_rate_reg) : decay_rate_reg;

    // per-stage valid bits and ready chain
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_ready;

    for (genvar i = 0; i < NS; i++) begin : g_flow
        logic valid_in;
        if (i == 0) begin : g_first
            assign valid_in = s_valid;
        end else begin : g_mid
            assign valid_in = valid_reg[i-1];
        end
        if (i == NS - 1) begin : g_last
            assign stage_ready[i] = !valid_reg[i] || m_ready;
        end else begin : g_inner
            assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (stage_ready[i]) begin
                valid_reg[i] <= valid_in;
            end
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NS-1];

    // carried side data
    tcn_pkg::exp_kind_t kind_reg [tcn_pkg::ST_SCALE:EST-1];
    logic [5:0]         n_reg    [tcn_pkg::ST_LOG2:EST-1];
    logic [31:0]        u_reg    [tcn_pkg::ST_FRAC:EST-3];

    // stage 0: sample magnitude
    logic [W-1:0] ax_reg;
    logic [W-1:0] ax_next;
    assign ax_next = s_sample[W-1] ? (W'(0) - W'(s_sample)) : W'(s_sample);

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_ABS]) begin
            ax_reg <= ax_next;
        end
    end

    // stage 1: scaled argument y = |x| * |R| in Q.24, classify the exponential
    logic [tcn_pkg::T_W-1:0] t_prod;
    logic [tcn_pkg::Y_W-1:0] y_full;
    logic [28:0]             y_reg;
    tcn_pkg::exp_kind_t      kind1_next;

    assign t_prod = tcn_pkg::T_W'(ax_reg) * tcn_pkg::T_W'(rate_abs);
    assign y_full = t_prod[tcn_pkg::T_W-1:12];

    always_comb begin
        if (ax_reg == '0 || rate_abs == '0) begin
            kind1_next = tcn_pkg::EXP_ONE;
        end else if (grow) begin
            kind1_next = tcn_pkg::EXP_TWO;
        end else if (y_full[tcn_pkg::Y_W-1:tcn_pkg::Y_FRAC_LIMIT_BITS] != '0) begin
            kind1_next = tcn_pkg::EXP_ZERO;
        end else begin
            kind1_next = tcn_pkg::EXP_CALC;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_SCALE]) begin
            y_reg                       <= y_full[28:0];
            kind_reg[tcn_pkg::ST_SCALE] <= kind1_next;
        end
    end

    // stage 2: z = y * log2(e), split into integer shift and fraction
    logic [53:0]        z_prod;
    logic [23:0]        f_reg;
    tcn_pkg::exp_kind_t kind2_next;

    assign z_prod = 54'(y_reg) * 54'(tcn_pkg::LOG2E_Q24);

    always_comb begin
        kind2_next = kind_reg[tcn_pkg::ST_SCALE];
        if (kind_reg[tcn_pkg::ST_SCALE] == tcn_pkg::EXP_CALC
                && z_prod[53:48] > tcn_pkg::MAX_SHIFT) begin
            kind2_next = tcn_pkg::EXP_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_LOG2]) begin
            f_reg                      <= z_prod[47:24];
            n_reg[tcn_pkg::ST_LOG2]    <= z_prod[53:48];
            kind_reg[tcn_pkg::ST_LOG2] <= kind2_next;
        end
    end

    // stage 3: u = fraction * ln 2 in Q.32
    logic [47:0] u_prod;
    assign u_prod = 48'(f_reg) * 48'(tcn_pkg::LN2_Q24);

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_FRAC]) begin
            u_reg[tcn_pkg::ST_FRAC]    <= u_prod[47:16];
            n_reg[tcn_pkg::ST_FRAC]    <= n_reg[tcn_pkg::ST_LOG2];
            kind_reg[tcn_pkg::ST_FRAC] <= kind_reg[tcn_pkg::ST_LOG2];
        end
    end

    // side data copied through the polynomial stages
    for (genvar i = HST; i < EST; i++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (stage_ready[i]) begin
                n_reg[i]    <= n_reg[i-1];
                kind_reg[i] <= kind_reg[i-1];
            end
        end
        if (i <= EST - 3) begin : g_u
            always_ff @(posedge aclk) begin
                if (stage_ready[i]) begin
                    u_reg[i] <= u_reg[i-1];
                end
            end
        end
    end

    // horner steps for exp(-u): a = 1 - ((u * a) >> 32) / k, k from 7 down to 1
    logic [31:0] pk_reg [HDEG];
    logic [32:0] a_reg  [HDEG];

    for (genvar j = 0; j < HDEG; j++) begin : g_horner
        logic [32:0] a_in;
        logic [64:0] ua_prod;
        logic [31:0] term;

        if (j == 0) begin : g_one
            assign a_in = tcn_pkg::ONE_Q32;
        end else begin : g_prev
            assign a_in = a_reg[j-1];
        end

        // multiply stage
        assign ua_prod = 65'(u_reg[HST + 2 * j - 1]) * 65'(a_in);
        always_ff @(posedge aclk) begin
            if (stage_ready[HST + 2 * j]) begin
                pk_reg[j] <= ua_prod[63:32];
            end
        end

        // divide and subtract stage
        assign term = tcn_pkg::div_small(pk_reg[j], HDEG - j);
        always_ff @(posedge aclk) begin
            if (stage_ready[HST + 2 * j + 1]) begin
                a_reg[j] <= tcn_pkg::ONE_Q32 - 33'(term);
            end
        end
    end

    // exponential in Q.32, special cases folded in
    logic [33:0] e_reg;
    logic [33:0] e_next;

    always_comb begin
        case (kind_reg[EST-1])
            tcn_pkg::EXP_ONE:  e_next = 34'(tcn_pkg::ONE_Q32);
            tcn_pkg::EXP_TWO:  e_next = tcn_pkg::TWO_Q32;
            tcn_pkg::EXP_ZERO: e_next = '0;
            default:           e_next = 34'(a_reg[HDEG-1] >> n_reg[EST-1]);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[EST]) begin
            e_reg <= e_next;
        end
    end

    // ratio m = F + (1 - F) * E, cut to Q.32
    logic [50:0] m_full;
    logic [34:0] m32_reg;

    assign m_full = {3'b000, floor_ratio_reg, 32'd0}
                  + 51'(tcn_pkg::ONE_Q16 - 17'(floor_ratio_reg)) * 51'(e_reg);

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_MIX]) begin
            m32_reg <= m_full[50:16];
        end
    end

    // scale by tau_max in two partial products
    logic [50:0] hi_prod;
    logic [47:0] lo_prod;
    logic [50:0] hi_reg;
    logic [31:0] lo_reg;

    assign hi_prod = 51'(tau_max_reg) * 51'(m32_reg[34:16]);
    assign lo_prod = 48'(tau_max_reg) * 48'(m32_reg[15:0]);

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_MUL]) begin
            hi_reg <= hi_prod;
            lo_reg <= lo_prod[47:16];
        end
    end

    // sum and apply bounds, tau_max wins over tau_min
    logic [51:0]      v_sum;
    logic [35:0]      v_raw;
    logic [35:0]      v_low;
    logic [31:0]      tau_next;
    tcn_pkg::bound_t  hit_low;
    tcn_pkg::bound_t  hit_next;
    logic [31:0]      tau_out_reg;
    tcn_pkg::bound_t  hit_reg;

    assign v_sum = 52'(hi_reg) + 52'(lo_reg);
    assign v_raw = v_sum[51:16];

    always_comb begin
        if (v_raw < 36'(tau_min_reg)) begin
            v_low   = 36'(tau_min_reg);
            hit_low = tcn_pkg::BOUND_MIN;
        end else begin
            v_low   = v_raw;
            hit_low = tcn_pkg::BOUND_NONE;
        end
        if (v_low > 36'(tau_max_reg)) begin
            tau_next = tau_max_reg;
            hit_next = tcn_pkg::BOUND_MAX;
        end else begin
            tau_next = v_low[31:0];
            hit_next = hit_low;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[tcn_pkg::ST_OUT]) begin
            tau_out_reg <= tau_next;
            hit_reg     <= hit_next;
        end
    end

    assign m_tau_out   = tau_out_reg;
    assign m_bound_hit = hit_reg;

    // checks
    `TCN_ASSERT_NEXT(a_input_enters, s_valid && s_ready, valid_reg[0])
    `TCN_ASSERT_NEXT(a_stall_holds, valid_reg[EST] && !stage_ready[EST + 1], valid_reg[EST])
    `TCN_ASSERT_NOW(a_poly_range, valid_reg[EST-1] && kind_reg[EST-1] == tcn_pkg::EXP_CALC, a_reg[HDEG-1] <= tcn_pkg::ONE_Q32 && a_reg[HDEG-1] != '0)
    `TCN_ASSERT_NOW(a_shift_range, valid_reg[tcn_pkg::ST_LOG2] && kind_reg[tcn_pkg::ST_LOG2] == tcn_pkg::EXP_CALC, n_reg[tcn_pkg::ST_LOG2] <= tcn_pkg::MAX_SHIFT)

endmodule

`default_nettype wire
